// ----- hw/rtl/idrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idrc_pkg
// Shared types, widths and codes of the inter-packet delay rate control core.
// ----------------------------------------------------------------------------
package idrc_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned BLK_W    = 32;
  localparam int unsigned LOSS_W   = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DELAY_W  = 22;
  localparam int unsigned FACT_W   = 16;
  localparam int unsigned TGT_W    = 20;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CIDX_W   = 3;

  // Datapath widths
  localparam int unsigned DEN_W  = 33;              // sd * span
  localparam int unsigned PROD_W = 34;              // (sn - sd) * m, signed
  localparam int unsigned NUM_W  = 35;              // den + prod, signed
  localparam int unsigned MULB_W = 34;              // positive numerator
  localparam int unsigned DVD_W  = DELAY_W + MULB_W;
  localparam int unsigned QUO_W  = 14;              // quotient bits kept
  localparam int unsigned DSH_W  = DEN_W + QUO_W;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

  // Constants
  localparam logic [LOSS_W-1:0]  LOSS_FULL  = LOSS_W'(100000);
  localparam logic [DELAY_W-1:0] DELAY_CEIL = DELAY_W'(10000);

  // Request codes
  localparam logic [ACT_W-1:0] ACT_ERR     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RESEND  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BEGIN   = 3'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RESTART = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_THR    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SN     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SD     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FN     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FD     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_TGT    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_TOTAL  = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_RTXOFF = 3'd7;

  // Configuration register file contents
  typedef struct packed {
    logic [LOSS_W-1:0] thr;
    logic [FACT_W-1:0] sn;
    logic [FACT_W-1:0] sd;
    logic [FACT_W-1:0] fn;
    logic [FACT_W-1:0] fd;
    logic [TGT_W-1:0]  tgt;
    logic [BLK_W-1:0]  total;
    logic              rtx_off;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul1;
    logic add;
    logic mul2;
    logic chk;
    logic div;
    logic fin;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_err;
  } sts_t;

endpackage

// ----- hw/rtl/idrc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idrc_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module idrc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [idrc_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [idrc_pkg::CFG_W-1:0]     cfg_data_i,
  output idrc_pkg::cfg_t                 cfg_o
);
  import idrc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode, data truncated to each register's width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THR:    cfg_d.thr     = cfg_data_i[LOSS_W-1:0];
        CFG_SN:     cfg_d.sn      = cfg_data_i[FACT_W-1:0];
        CFG_SD:     cfg_d.sd      = cfg_data_i[FACT_W-1:0];
        CFG_FN:     cfg_d.fn      = cfg_data_i[FACT_W-1:0];
        CFG_FD:     cfg_d.fd      = cfg_data_i[FACT_W-1:0];
        CFG_TGT:    cfg_d.tgt     = cfg_data_i[TGT_W-1:0];
        CFG_TOTAL:  cfg_d.total   = cfg_data_i[BLK_W-1:0];
        CFG_RTXOFF: cfg_d.rtx_off = cfg_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr     <= '0;
      cfg_q.sn      <= FACT_W'(25);
      cfg_q.sd      <= FACT_W'(24);
      cfg_q.fn      <= FACT_W'(5);
      cfg_q.fd      <= FACT_W'(6);
      cfg_q.tgt     <= '0;
      cfg_q.total   <= '0;
      cfg_q.rtx_off <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/idrc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idrc_ctrl
// Sequencer: steps the datapath through multiply, add, range check and serial
// divide for error reports, and owns the input stall and output word valid.
// ----------------------------------------------------------------------------
module idrc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  idrc_pkg::sts_t sts_i,
  output idrc_pkg::cmd_t cmd_o
);
  import idrc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  cmd_t             cmd;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_d  = sts_i.is_err ? S_ADD : S_FIN;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        cnt_d   = CNT_W'(DIV_STEPS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        // wait for the output register to be free
        if (!out_valid_q || !out_stall_i) begin
          cmd.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.fin) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Accepted word always starts the sequence
  a_accept_to_mul1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL1))
    else $error("accepted word did not start the sequence");

  // Result only loaded when the output register can take it
  a_fin_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending output word");

  // Loaded result is presented next cycle
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> out_valid_q)
    else $error("finished result not presented");

  // Divide ends after its last step
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_FIN))
    else $error("divide did not finish on its last step");

endmodule

// ----- hw/rtl/idrc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idrc_dpath
// Datapath: request registers, delay and position state, the delay scaling
// arithmetic with a restoring divider, and the output word register.
// ----------------------------------------------------------------------------
module idrc_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  idrc_pkg::cfg_t                   cfg_i,
  input  idrc_pkg::cmd_t                   cmd_i,
  output idrc_pkg::sts_t                   sts_o,
  input  logic [idrc_pkg::ACT_W-1:0]       action_i,
  input  logic [idrc_pkg::BLK_W-1:0]       block_number_i,
  input  logic [idrc_pkg::LOSS_W-1:0]      reported_loss_i,
  output logic [idrc_pkg::STATUS_W-1:0]    status_o,
  output logic [idrc_pkg::DELAY_W-1:0]     delay_now_o,
  output logic [idrc_pkg::BLK_W-1:0]       position_now_o,
  output logic                             resend_valid_o,
  output logic [idrc_pkg::BLK_W-1:0]       resend_block_o
);
  import idrc_pkg::*;

  // Request registers
  logic [ACT_W-1:0]  act_q;
  logic [BLK_W-1:0]  blk_q;
  logic [LOSS_W-1:0] loss_q;

  // Architectural state
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [BLK_W-1:0]   pos_q, pos_d;

  // Arithmetic registers
  logic                     slow_q;
  logic [DEN_W-1:0]         den_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [NUM_W-1:0]  num_q;
  logic [DVD_W-1:0]         dvd_q;
  logic [DEN_W-1:0]         dvs_q;
  logic                     ovf_q;
  logic [DSH_W-1:0]         rem_q, dsh_q;
  logic [QUO_W-1:0]         quo_q;

  // Output word registers
  logic [STATUS_W-1:0] status_q, status_d;
  logic                rv_q, rv_d;
  logic [BLK_W-1:0]    rb_q, rb_d;

  // First multiply stage operands
  logic [LOSS_W-1:0]        e_sat, span, m;
  logic                     slow;
  logic signed [FACT_W:0]   diff;
  logic signed [LOSS_W:0]   m_s;
  logic [MULB_W-1:0]        mul_b;
  logic [DELAY_W-1:0]       raw, capped, adj;

  assign e_sat = (loss_q > LOSS_FULL) ? LOSS_FULL : loss_q;
  assign slow  = (e_sat > cfg_i.thr);
  assign span  = LOSS_FULL - cfg_i.thr;
  assign m     = LOSS_W'(e_sat - cfg_i.thr + LOSS_W'(1));
  assign diff  = $signed({1'b0, cfg_i.sn}) - $signed({1'b0, cfg_i.sd});
  assign m_s   = $signed({1'b0, m});

  // Second multiply operand: positive numerator or speedup factor
  assign mul_b = slow_q ? num_q[MULB_W-1:0] : MULB_W'(cfg_i.fn);

  // Request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      blk_q  <= block_number_i;
      loss_q <= reported_loss_i;
    end
  end

  // Scaling arithmetic and restoring divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      slow_q <= slow;
      den_q  <= DEN_W'(cfg_i.sd) * DEN_W'(span);
      prod_q <= PROD_W'(diff) * PROD_W'(m_s);
    end
    if (cmd_i.add) begin
      num_q <= NUM_W'($signed({1'b0, den_q})) + NUM_W'(prod_q);
    end
    if (cmd_i.mul2) begin
      dvd_q <= DVD_W'(delay_q) * DVD_W'(mul_b);
      dvs_q <= slow_q ? den_q : DEN_W'(cfg_i.fd);
    end
    if (cmd_i.chk) begin
      ovf_q <= (dvd_q >= DVD_W'({dvs_q, QUO_W'(0)}));
      rem_q <= dvd_q[DSH_W-1:0];
      dsh_q <= DSH_W'({dvs_q, (QUO_W - 1)'(0)});
      quo_q <= '0;
    end
    if (cmd_i.div) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // Scaled delay: zero divisor keeps it, non-positive numerator zeroes it
  always_comb begin
    priority if (dvs_q == '0) begin
      raw = delay_q;
    end else if (slow_q && (num_q[NUM_W-1] || num_q == '0)) begin
      raw = '0;
    end else if (ovf_q) begin
      raw = DELAY_CEIL;
    end else begin
      raw = DELAY_W'(quo_q);
    end
    capped = (raw > DELAY_CEIL) ? DELAY_CEIL : raw;
    adj    = (capped < DELAY_W'(cfg_i.tgt)) ? DELAY_W'(cfg_i.tgt) : capped;
  end

  // Request outcome
  always_comb begin
    delay_d  = delay_q;
    pos_d    = pos_q;
    status_d = ST_OK;
    rv_d     = 1'b0;
    rb_d     = '0;
    unique case (act_q)
      ACT_ERR: delay_d = adj;
      ACT_RESTART: begin
        if (blk_q == '0 || blk_q > cfg_i.total) begin
          status_d = ST_BAD_RESTART;
        end else begin
          pos_d = blk_q;
        end
      end
      ACT_RESEND: begin
        if (!cfg_i.rtx_off) begin
          rv_d = 1'b1;
          rb_d = blk_q;
        end
      end
      ACT_BEGIN: begin
        pos_d   = '0;
        delay_d = DELAY_W'(cfg_i.tgt) * DELAY_W'(3);
      end
      default: status_d = ST_UNKNOWN;
    endcase
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.fin) begin
      delay_q <= delay_d;
      pos_q   <= pos_d;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q <= status_d;
      rv_q     <= rv_d;
      rb_q     <= rb_d;
    end
  end

  assign sts_o.is_err   = (act_q == ACT_ERR);
  assign status_o       = status_q;
  assign delay_now_o    = delay_q;
  assign position_now_o = pos_q;
  assign resend_valid_o = rv_q;
  assign resend_block_o = rb_q;

endmodule

// ----- hw/rtl/interpacket_delay_rate_control_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpacket_delay_rate_control_core
// Sender-side feedback handler: inter-packet delay and block position control.
// ----------------------------------------------------------------------------
// Takes one client request word at a time and returns one result word. An
// error report runs through a multiply, an add, a second multiply, a range
// check, 14 restoring divide steps and the finish state; other requests go
// from the first multiply straight to finish. The next word is accepted in
// the cycle after the result is loaded, so no new word is taken before the
// last is through; a result held in the output register by out_stall holds
// the next one in its finish state. delay_now and position_now show the state
// after the request. The user must write configuration through the indexed
// write port while no request is in flight; the core does not enforce this.
module interpacket_delay_rate_control_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [idrc_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [idrc_pkg::CFG_W-1:0]    cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [idrc_pkg::ACT_W-1:0]    action_i,
  input  logic [idrc_pkg::BLK_W-1:0]    block_number_i,
  input  logic [idrc_pkg::LOSS_W-1:0]   reported_loss_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [idrc_pkg::STATUS_W-1:0] status_o,
  output logic [idrc_pkg::DELAY_W-1:0]  delay_now_o,
  output logic [idrc_pkg::BLK_W-1:0]    position_now_o,
  output logic                          resend_valid_o,
  output logic [idrc_pkg::BLK_W-1:0]    resend_block_o
);
  import idrc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers
  idrc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sequencer
  idrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  idrc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .block_number_i  (block_number_i),
    .reported_loss_i (reported_loss_i),
    .status_o        (status_o),
    .delay_now_o     (delay_now_o),
    .position_now_o  (position_now_o),
    .resend_valid_o  (resend_valid_o),
    .resend_block_o  (resend_block_o)
  );

endmodule
